// ----- design/l11enc_pkg.sv -----
// Shared types and constants for the LINEAR11 encoder pipeline.
`default_nettype none

package l11enc_pkg;

	// Arithmetic constants
	localparam int          SHIFT_COUNT = 12;
	localparam int          IN_W        = 20;
	localparam int          MANT_W      = 11;
	localparam int          REM_W       = 10;
	localparam int          KEY_W       = REM_W + SHIFT_COUNT - 1;
	localparam int          IDX_W       = 4;
	localparam int          EXP_W       = 5;
	localparam int          RECIP_W     = 21;
	localparam int          RECIP_SHIFT = 30;
	localparam int          PROD_W      = IN_W + RECIP_W;
	localparam int          MANT_LIMIT  = 1024000;
	localparam logic [10:0] MILLI_DIV   = 11'd1000;
	localparam logic [20:0] RECIP       = 21'd1073742;
	localparam logic [15:0] SAT_WORD    = 16'h03FF;

	typedef logic [REM_W-1:0]  rem_t;
	typedef logic [MANT_W-1:0] mant_t;

	// Quotient and remainder of the input by one thousand
	typedef struct packed {
		logic                   vld;
		logic                   sat;
		logic [SHIFT_COUNT-1:0] ok;
		mant_t                  q0;
		rem_t                   r0;
	} div_res_t;

	// Remainder and mantissa for every shift
	typedef struct packed {
		logic                   vld;
		logic                   sat;
		logic [SHIFT_COUNT-1:0] ok;
		rem_t [SHIFT_COUNT-1:0] r;
		mant_t [SHIFT_COUNT-1:0] q;
	} lanes_t;

endpackage

`default_nettype wire

// ----- design/l11enc_div.sv -----
// Input register and divide-by-thousand front end.
`default_nettype none

module l11enc_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [19:0]                milli_value,
	output l11enc_pkg::div_res_t            res
);
	import l11enc_pkg::*;

	logic              vld_s1;
	logic [IN_W-1:0]   v_s1;
	logic              vld_s2;
	logic [IN_W-1:0]   v_s2;
	logic [PROD_W-1:0] prod_s2;
	div_res_t          res_s3;

	mant_t                  q_c;
	logic [IN_W:0]          r_full_c;
	logic [SHIFT_COUNT-1:0] ok_c;

	// Capture the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_s1 <= milli_value;
		end
	end

	// Multiply by the scaled reciprocal of one thousand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		v_s2    <= v_s1;
		prod_s2 <= PROD_W'(v_s1) * PROD_W'(RECIP);
	end

	// Take quotient, remainder and the range of usable shifts
	always_comb begin
		q_c      = prod_s2[RECIP_SHIFT +: MANT_W];
		r_full_c = (IN_W+1)'(v_s2) - (IN_W+1)'(q_c) * (IN_W+1)'(MILLI_DIV);
		for (int i = 0; i < SHIFT_COUNT; i++) begin
			ok_c[i] = (v_s2 < IN_W'(MANT_LIMIT >> i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s3 <= '0;
		end else begin
			res_s3.vld <= vld_s2;
			res_s3.sat <= ~ok_c[0];
			res_s3.ok  <= ok_c;
			res_s3.q0  <= q_c;
			res_s3.r0  <= r_full_c[REM_W-1:0];
		end
	end

	assign res = res_s3;

endmodule

`default_nettype wire

// ----- design/l11enc_dbl.sv -----
// Doubling chain: remainder and mantissa of the input at every shift.
`default_nettype none

module l11enc_dbl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire l11enc_pkg::div_res_t div_in,
	output l11enc_pkg::lanes_t        lanes
);
	import l11enc_pkg::*;

	localparam int HALF = 7;

	lanes_t lanes_s4;
	lanes_t lanes_s5;
	rem_t   r_lo_c [HALF];
	mant_t  q_lo_c [HALF];
	rem_t   r_hi_c [SHIFT_COUNT];
	mant_t  q_hi_c [SHIFT_COUNT];

	// Shifts zero to six: double the remainder, fold back past one thousand
	always_comb begin
		logic [REM_W:0] r2;
		logic           c;
		r_lo_c[0] = div_in.r0;
		q_lo_c[0] = div_in.q0;
		for (int i = 1; i < HALF; i++) begin
			r2        = {r_lo_c[i-1], 1'b0};
			c         = (r2 >= MILLI_DIV);
			r_lo_c[i] = c ? REM_W'(r2 - MILLI_DIV) : r2[REM_W-1:0];
			q_lo_c[i] = {q_lo_c[i-1][MANT_W-2:0], c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_s4 <= '0;
		end else begin
			lanes_s4.vld <= div_in.vld;
			lanes_s4.sat <= div_in.sat;
			lanes_s4.ok  <= div_in.ok;
			for (int i = 0; i < HALF; i++) begin
				lanes_s4.r[i] <= r_lo_c[i];
				lanes_s4.q[i] <= q_lo_c[i];
			end
			for (int i = HALF; i < SHIFT_COUNT; i++) begin
				lanes_s4.r[i] <= '0;
				lanes_s4.q[i] <= '0;
			end
		end
	end

	// Shifts seven to eleven continue from shift six
	always_comb begin
		logic [REM_W:0] r2;
		logic           c;
		for (int i = 0; i < SHIFT_COUNT; i++) begin
			r_hi_c[i] = lanes_s4.r[i];
			q_hi_c[i] = lanes_s4.q[i];
		end
		for (int i = HALF; i < SHIFT_COUNT; i++) begin
			r2        = {r_hi_c[i-1], 1'b0};
			c         = (r2 >= MILLI_DIV);
			r_hi_c[i] = c ? REM_W'(r2 - MILLI_DIV) : r2[REM_W-1:0];
			q_hi_c[i] = {q_hi_c[i-1][MANT_W-2:0], c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_s5 <= '0;
		end else begin
			lanes_s5.vld <= lanes_s4.vld;
			lanes_s5.sat <= lanes_s4.sat;
			lanes_s5.ok  <= lanes_s4.ok;
			for (int i = 0; i < SHIFT_COUNT; i++) begin
				lanes_s5.r[i] <= r_hi_c[i];
				lanes_s5.q[i] <= q_hi_c[i];
			end
		end
	end

	assign lanes = lanes_s5;

endmodule

`default_nettype wire

// ----- design/l11enc_sel.sv -----
// Least-error shift selection and result register.
`default_nettype none

module l11enc_sel (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire l11enc_pkg::lanes_t lanes,
	output logic                    done,
	output logic [15:0]             linear_word,
	output logic                    out_of_range
);
	import l11enc_pkg::*;

	localparam int PAIRS = SHIFT_COUNT / 2;

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] key;
		mant_t            mant;
	} cand_t;

	// Keep the lower shift unless the upper one is usable and either the lower is not or the upper is strictly better
	function automatic cand_t pick(input cand_t lo, input cand_t hi);
		if (hi.ok && (!lo.ok || hi.key < lo.key)) begin
			return hi;
		end
		return lo;
	endfunction

	cand_t cand_c [SHIFT_COUNT];
	cand_t pair_s6 [PAIRS];
	logic  vld_s6;
	logic  sat_s6;
	cand_t quad_c [3];
	cand_t best_c;

	logic             done_q;
	logic [15:0]      word_q;
	logic             oor_q;

	// Scale each error to a common denominator and reduce pairwise
	always_comb begin
		for (int i = 0; i < SHIFT_COUNT; i++) begin
			cand_c[i].ok   = lanes.ok[i];
			cand_c[i].idx  = IDX_W'(i);
			cand_c[i].key  = KEY_W'(lanes.r[i]) << (SHIFT_COUNT - 1 - i);
			cand_c[i].mant = lanes.q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= lanes.vld;
		end
	end

	always_ff @(posedge clk) begin
		sat_s6 <= lanes.sat;
		for (int i = 0; i < PAIRS; i++) begin
			pair_s6[i] <= pick(cand_c[2*i], cand_c[2*i+1]);
		end
	end

	// Finish the reduction in shift order so the lowest shift wins a tie
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quad_c[i] = pick(pair_s6[2*i], pair_s6[2*i+1]);
		end
		best_c = pick(pick(quad_c[0], quad_c[1]), quad_c[2]);
	end

	// Form the word and present it for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (sat_s6) begin
			word_q <= SAT_WORD;
			oor_q  <= 1'b1;
		end else begin
			word_q <= {EXP_W'(EXP_W'(0) - EXP_W'(best_c.idx)), best_c.mant};
			oor_q  <= 1'b0;
		end
	end

	assign done         = done_q;
	assign linear_word  = word_q;
	assign out_of_range = oor_q;

endmodule

`default_nettype wire

// ----- design/milli_to_linear11_encoder.sv -----
// Top level of the milli-unit to LINEAR11 encoder.
//
// Usage:
//   Drive milli_value and raise start for one cycle per item; an item is
//   taken at every rising edge where start is high and busy is low. busy is
//   always low, so a new item may enter in every cycle.
//   Each item yields one result: linear_word and out_of_range are valid in
//   the single cycle in which done is high. The receiver cannot stall the
//   block; results must be taken as they appear.
//   Throughput is one item per cycle. The stages are the input register,
//   the reciprocal multiply, the quotient and remainder step, two stages
//   of the remainder doubling chain, one stage of the least-error reduction
//   tree, and the result register, which finishes the reduction.
//   Values of 1024000 and above give 0x03FF with out_of_range set.
//   Reset clears all valid flags at once; items in flight are dropped and
//   done stays low until new items arrive.
`default_nettype none

module milli_to_linear11_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [19:0] milli_value,
	output logic             done,
	output logic [15:0]      linear_word,
	output logic             out_of_range
);
	import l11enc_pkg::*;

	div_res_t div_res;
	lanes_t   lanes;
	logic     accept;

	// Fully pipelined: never hold off an item
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	l11enc_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.milli_value (milli_value),
		.res         (div_res)
	);

	l11enc_dbl u_dbl (
		.clk    (clk),
		.arst_n (arst_n),
		.div_in (div_res),
		.lanes  (lanes)
	);

	l11enc_sel u_sel (
		.clk          (clk),
		.arst_n       (arst_n),
		.lanes        (lanes),
		.done         (done),
		.linear_word  (linear_word),
		.out_of_range (out_of_range)
	);

	// Every accepted item comes out as a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##7 done)
		else $error("result missing seven cycles after accept");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 7))
		else $error("result without a matching item");

	// Saturated results carry the fixed word
	a_sat_word: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range) |-> (linear_word == SAT_WORD))
		else $error("out-of-range item without saturated word");

	// In-range mantissa never reaches the sign bit of the field
	a_mant_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_of_range) |-> (linear_word[10] == 1'b0))
		else $error("mantissa exceeds 1023");

endmodule

`default_nettype wire
